/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, operation and status codes, and index helpers for the
// circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    // number of slots in the circular store
    localparam int unsigned DEPTH = 8;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DATA_W = 32;

    typedef logic [IDX_W-1:0] idx_t;

    // operation codes carried by an input transfer
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);

    // index plus one, modulo DEPTH
    function automatic idx_t wrap_inc(input idx_t i);
        return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
    endfunction

    // index minus one, modulo DEPTH
    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
    endfunction

endpackage

/* rtl/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular slot RAM: push/pop at front or rear,
// with full and empty rejection status.
// ----------------------------------------------------------------------------
// Pipeline: the input transfer registers the slot RAM read and the read stage,
// then the output register raises m_valid. Throughput: one operation per
// cycle while m_ready is high; a stalled result holds the read stage and
// drops s_ready.
// Reset: indices clear to zero, the deque reads empty, pipeline and output
// valids clear; slot contents are left as they are.
module circular_deque (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [31:0] s_push_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pop_value,
    output logic [1:0]         m_status
);

    cdq_pkg::idx_t    head_reg, head_next;
    cdq_pkg::idx_t    tail_reg, tail_next;
    logic             empty_reg, empty_next;

    logic             p1_valid_reg;
    logic             p1_pop_ok_reg;
    cdq_pkg::status_t p1_status_reg;
    cdq_pkg::status_t status_next;
    logic             pop_ok_next;

    logic             m_valid_reg;
    logic [31:0]      m_pop_value_reg;
    cdq_pkg::status_t m_status_reg;

    logic             accept;
    logic             p1_advance;
    logic             full;
    logic             ram_en;
    logic             ram_we;
    cdq_pkg::idx_t    ram_addr;
    logic [31:0]      ram_rdata;
    cdq_pkg::kind_t   kind;

    assign kind       = cdq_pkg::kind_t'(s_kind);
    assign p1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !p1_valid_reg || p1_advance;
    assign accept     = s_valid && s_ready;
    assign full       = !empty_reg && (head_reg == cdq_pkg::wrap_inc(tail_reg));

    // index update, status and slot access for the accepted operation
    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = cdq_pkg::ST_DONE;
        pop_ok_next = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = '0;
        if (accept) begin
            case (kind)
                cdq_pkg::KIND_PUSH_FRONT, cdq_pkg::KIND_PUSH_REAR: begin
                    if (full) begin
                        status_next = cdq_pkg::ST_FULL;
                    end else if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        ram_addr   = '0;
                    end else if (kind == cdq_pkg::KIND_PUSH_FRONT) begin
                        head_next = cdq_pkg::wrap_dec(head_reg);
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = cdq_pkg::wrap_dec(head_reg);
                    end else begin
                        tail_next = cdq_pkg::wrap_inc(tail_reg);
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                        ram_addr  = cdq_pkg::wrap_inc(tail_reg);
                    end
                end
                cdq_pkg::KIND_POP_FRONT, cdq_pkg::KIND_POP_REAR: begin
                    if (empty_reg) begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end else begin
                        pop_ok_next = 1'b1;
                        ram_en      = 1'b1;
                        ram_addr    = (kind == cdq_pkg::KIND_POP_FRONT) ? head_reg
                                                                        : tail_reg;
                        if (head_reg == tail_reg) begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                        end else if (kind == cdq_pkg::KIND_POP_FRONT) begin
                            head_next = cdq_pkg::wrap_inc(head_reg);
                        end else begin
                            tail_next = cdq_pkg::wrap_dec(tail_reg);
                        end
                    end
                end
                default: begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // slot store
    cdq_ram #(
        .WIDTH(cdq_pkg::DATA_W),
        .DEPTH(cdq_pkg::DEPTH)
    ) u_slots (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(s_push_value),
        .rdata(ram_rdata)
    );

    // deque indices and empty flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    // read stage: waits for the RAM data of a pop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_pop_ok_reg <= pop_ok_next;
            p1_status_reg <= status_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance && p1_valid_reg) begin
            m_pop_value_reg <= p1_pop_ok_reg ? ram_rdata : '0;
            m_status_reg    <= p1_status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pop_value = signed'(m_pop_value_reg);
    assign m_status    = m_status_reg;

    // empty deque always parks both indices at zero
    a_empty_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty deque with nonzero index");

    // a rejected push leaves the indices alone
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && (kind == cdq_pkg::KIND_PUSH_FRONT
                            || kind == cdq_pkg::KIND_PUSH_REAR))
        |=> $stable(head_reg) && $stable(tail_reg) && !empty_reg)
        else $error("push on full deque moved an index");

    // a pop of an empty deque reports empty status
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && empty_reg && (kind == cdq_pkg::KIND_POP_FRONT
                                 || kind == cdq_pkg::KIND_POP_REAR))
        |=> p1_status_reg == cdq_pkg::ST_EMPTY && !p1_pop_ok_reg)
        else $error("pop on empty deque not reported");

    // pop read data holds while the read stage is stalled
    a_rdata_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_pop_ok_reg && !p1_advance) |=> $stable(ram_rdata))
        else $error("slot read data changed under a stalled result");

endmodule

/* rtl/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or registered read, one access a cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_deque. A short stimulus table covers
// empty and full rejection, value extremes, index wrap and draining to
// empty. Biased random operations follow, keeping the deque near full
// and near empty. Every result transfer is checked against an in-bench
// deque model or a table literal. Random idle bursts are applied on both handshakes.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM = 630;
    localparam int N_CALM   = 100;
    localparam int N_DIR    = 23;

    // one stimulus row: operation, value, and an optional literal result
    typedef struct packed {
        cdq_pkg::kind_t   kind;
        logic [31:0]      value;
        logic             lit;
        logic [31:0]      lit_pop;
        cdq_pkg::status_t lit_status;
    } stim_row_t;

    typedef struct packed {
        logic [31:0]      pop_value;
        cdq_pkg::status_t status;
    } deque_reply_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic signed [31:0] s_push_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pop_value;
    logic [1:0]         m_status;

    // model of the deque contents
    logic [31:0]   model_slot [cdq_pkg::DEPTH];
    cdq_pkg::idx_t model_head;
    cdq_pkg::idx_t model_tail;
    logic          model_empty;

    deque_reply_t deque_replies_q [$];
    stim_row_t    stim_tab [N_DIR];

    int  n_sent;
    int  n_checked;
    int  n_err;
    int  n_full;
    int  n_empty;
    bit  calm;
    bit  tx_quiet;
    bit  rx_quiet;

    circular_deque uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // apply one operation to the model and return what the block should answer
    function automatic deque_reply_t deque_predict(input cdq_pkg::kind_t k,
                                                   input logic [31:0] v);
        deque_reply_t r;
        logic         full;
        r.pop_value = '0;
        r.status    = cdq_pkg::ST_DONE;
        full = !model_empty
               && (cdq_pkg::idx_t'((int'(model_tail) + 1) % cdq_pkg::DEPTH) == model_head);
        if (k == cdq_pkg::KIND_PUSH_FRONT || k == cdq_pkg::KIND_PUSH_REAR) begin
            if (full) begin
                r.status = cdq_pkg::ST_FULL;
            end else if (model_empty) begin
                model_head    = '0;
                model_tail    = '0;
                model_empty   = 1'b0;
                model_slot[0] = v;
            end else if (k == cdq_pkg::KIND_PUSH_FRONT) begin
                model_head = cdq_pkg::idx_t'((int'(model_head) + cdq_pkg::DEPTH - 1)
                                            % cdq_pkg::DEPTH);
                model_slot[model_head] = v;
            end else begin
                model_tail = cdq_pkg::idx_t'((int'(model_tail) + 1) % cdq_pkg::DEPTH);
                model_slot[model_tail] = v;
            end
        end else begin
            if (model_empty) begin
                r.status = cdq_pkg::ST_EMPTY;
            end else begin
                r.pop_value = (k == cdq_pkg::KIND_POP_FRONT) ? model_slot[model_head]
                                                             : model_slot[model_tail];
                // last element leaves both indices at zero
                if (model_head == model_tail) begin
                    model_empty = 1'b1;
                    model_head  = '0;
                    model_tail  = '0;
                end else if (k == cdq_pkg::KIND_POP_FRONT) begin
                    model_head = cdq_pkg::idx_t'((int'(model_head) + 1) % cdq_pkg::DEPTH);
                end else begin
                    model_tail = cdq_pkg::idx_t'((int'(model_tail) + cdq_pkg::DEPTH - 1)
                                                % cdq_pkg::DEPTH);
                end
            end
        end
        return r;
    endfunction

    // drive one operation and hold it until the transfer; called at a falling edge
    task automatic send_op(input cdq_pkg::kind_t k, input logic [31:0] v,
                           input logic lit, input deque_reply_t lit_reply);
        deque_reply_t r;
        int           gap;
        if (!calm && !tx_quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_push_value <= v;
        do @(posedge aclk); while (!s_ready);
        r = deque_predict(k, v);
        if (lit) r = lit_reply;
        if (r.status == cdq_pkg::ST_FULL) n_full++;
        if (r.status == cdq_pkg::ST_EMPTY) n_empty++;
        deque_replies_q.push_back(r);
        n_sent++;
        @(negedge aclk);
    endtask

    // result side back-pressure
    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 48 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!calm && !rx_quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        deque_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (deque_replies_q.size() == 0) begin
                $display("%0t: unexpected result pop_value=%h status=%0d",
                         $time, m_pop_value, m_status);
                n_err++;
            end else begin
                want = deque_replies_q.pop_front();
                if (m_pop_value !== want.pop_value) begin
                    $display("%0t: pop_value mismatch expected=%h actual=%h",
                             $time, want.pop_value, m_pop_value);
                    n_err++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d",
                             $time, want.status, m_status);
                    n_err++;
                end
                n_checked++;
            end
        end
    end

    // stimulus
    initial begin
        deque_reply_t   lit_reply;
        deque_reply_t   none;
        cdq_pkg::kind_t k;
        logic [31:0]    v;
        int             mode;
        int             pick;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = cdq_pkg::KIND_PUSH_FRONT;
        s_push_value = '0;
        calm         = 1'b0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        n_sent       = 0;
        n_checked    = 0;
        n_err        = 0;
        n_full       = 0;
        n_empty      = 0;
        model_head   = '0;
        model_tail   = '0;
        model_empty  = 1'b1;
        none         = '0;
        mode         = 0;

        // pops on the fresh deque, fill to full with extremes, reject, drain, then an empty pop and a push and pop
        stim_tab = '{
            '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0, cdq_pkg::ST_EMPTY},
            '{cdq_pkg::KIND_POP_REAR,   32'h1234_5678, 1'b1, 32'h0, cdq_pkg::ST_EMPTY},
            '{cdq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_REAR,  32'h8000_0000, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_REAR,  32'h0000_0000, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_REAR,  32'h0000_0001, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_FRONT, 32'h5555_5555, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_REAR,  32'haaaa_aaaa, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_PUSH_FRONT, 32'hdead_beef, 1'b1, 32'h0, cdq_pkg::ST_FULL},
            '{cdq_pkg::KIND_PUSH_REAR,  32'hcafe_f00d, 1'b1, 32'h0, cdq_pkg::ST_FULL},
            '{cdq_pkg::KIND_POP_FRONT,  32'hffff_ffff, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_REAR,   32'hffff_ffff, 1'b1, 32'h0, cdq_pkg::ST_EMPTY},
            '{cdq_pkg::KIND_PUSH_REAR,  32'h0f0f_0f0f, 1'b1, 32'h0, cdq_pkg::ST_DONE},
            '{cdq_pkg::KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, cdq_pkg::ST_DONE}
        };

        // reset
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // table walk
        for (int i = 0; i < N_DIR; i++) begin
            lit_reply.pop_value = stim_tab[i].lit_pop;
            lit_reply.status    = stim_tab[i].lit_status;
            send_op(stim_tab[i].kind, stim_tab[i].value, stim_tab[i].lit, lit_reply);
        end

        // random operations, biased in runs toward filling or draining
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 25 == 0) mode = $urandom_range(0, 2);
            if (i % 32 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
            if (i == N_RANDOM - N_CALM) calm = 1'b1;
            pick = $urandom_range(0, 99);
            case (mode)
                0: k = (pick < 75) ? cdq_pkg::KIND_PUSH_FRONT : cdq_pkg::KIND_POP_FRONT;
                1: k = (pick < 25) ? cdq_pkg::KIND_PUSH_FRONT : cdq_pkg::KIND_POP_FRONT;
                default: k = (pick < 50) ? cdq_pkg::KIND_PUSH_FRONT
                                         : cdq_pkg::KIND_POP_FRONT;
            endcase
            // pick the end of the deque
            if ($urandom_range(0, 1) == 1) begin
                k = (k == cdq_pkg::KIND_PUSH_FRONT) ? cdq_pkg::KIND_PUSH_REAR
                                                    : cdq_pkg::KIND_POP_REAR;
            end
            case ($urandom_range(0, 11))
                0: v = 32'h7fff_ffff;
                1: v = 32'h8000_0000;
                2: v = 32'hffff_ffff;
                3: v = 32'h0000_0000;
                default: v = $urandom;
            endcase
            send_op(k, v, 1'b0, none);
        end
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (deque_replies_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("ran %0d operations, %0d results checked, %0d errors",
                 n_sent, n_checked, n_err);
        $display("rejections seen: %0d on full, %0d on empty", n_full, n_empty);
        if (n_err == 0) begin
            $display("PASS circular_deque");
        end else begin
            $display("FAIL circular_deque");
        end
        $finish;
    end

    // watchdog
    initial begin
        #500000;
        $display("timeout with %0d results outstanding", deque_replies_q.size());
        $display("FAIL circular_deque");
        $finish;
    end

endmodule
